// File: rtl/cia_pkg.sv
// Shared operation codes, status codes and control types of the checked integer ALU.
`default_nettype none
package cia_pkg;
    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_ADD = 4'd0;
    localparam logic [OP_W-1:0] OP_SUB = 4'd1;
    localparam logic [OP_W-1:0] OP_MUL = 4'd2;
    localparam logic [OP_W-1:0] OP_DIV = 4'd3;
    localparam logic [OP_W-1:0] OP_REM = 4'd4;
    localparam logic [OP_W-1:0] OP_LT  = 4'd5;
    localparam logic [OP_W-1:0] OP_LE  = 4'd6;
    localparam logic [OP_W-1:0] OP_GT  = 4'd7;
    localparam logic [OP_W-1:0] OP_GE  = 4'd8;

    localparam int ST_W = 2;
    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_BADTYPE  = 2'd1;
    localparam logic [ST_W-1:0] ST_OVERFLOW = 2'd2;
    localparam logic [ST_W-1:0] ST_DIVZERO  = 2'd3;

    localparam logic CFG_SMALL_MIN = 1'b0;
    localparam logic CFG_SMALL_MAX = 1'b1;

    localparam logic [63:0] SMALL_MIN_RESET = 64'hF800_0000_0000_0000;
    localparam logic [63:0] SMALL_MAX_RESET = 64'h07FF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [ST_W-1:0] status;
        logic            truth;
        logic            neg_q;
        logic            neg_r;
    } ctl_t;
endpackage
`default_nettype wire

// File: rtl/checked_integer_alu.sv
// Top level of the overflow-checked signed integer ALU.
//
// Input stream (s_axis_*): one operation per transaction, operation code and two
// signed operands in tdata, the two integer-type flags in tuser. Output stream
// (m_axis_*): one result transaction per input transaction, in order, carrying
// the value, comparison truth bit, status and the needs-box flag.
// The configuration port writes small_min (index 0) and small_max (index 1);
// write it only while no transaction is in flight.
// Each transaction passes through the input queue, one stage per quotient bit
// of the divider, and the output register. Every operation takes the same path,
// so the block accepts one transaction per cycle while the receiver does not
// stall, and results leave in order.
// When the receiver stalls, the whole execution pipeline holds; the two-entry
// queue keeps accepting until it is full, then s_axis_tready drops.
// Reset empties the queue and pipeline and restores the default small range.
`default_nettype none
module checked_integer_alu
    import cia_pkg::*;
#(
    parameter int DATA_WIDTH = 64
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // [3:0] operation, [67:4] operand_a, [131:68] operand_b, [135:132] zero
    input  wire logic [135:0] s_axis_tdata,
    // [0] a_is_int, [1] b_is_int
    input  wire logic [1:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [63:0] result_value, [64] truth, [66:65] status, [67] needs_box, [71:68] zero
    output logic [71:0]       m_axis_tdata,
    input  wire logic         cfg_we,
    input  wire logic         cfg_index,
    input  wire logic [63:0]  cfg_data
);
    localparam int W = DATA_WIDTH;
    localparam int QW = $bits(ctl_t) + 3 * W;

    logic [63:0]     small_min_reg;
    logic [63:0]     small_max_reg;
    ctl_t            f_ctl, q_ctl;
    logic [W-1:0]    f_val, f_mag_a, f_mag_b;
    logic [W-1:0]    q_val, q_mag_a, q_mag_b;
    logic [QW-1:0]   q_rd_data;
    logic            q_rd_valid;
    logic            q_rd_ready;
    logic [63:0]     r_value;
    logic            r_truth;
    logic [ST_W-1:0] r_status;
    logic            r_box;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            small_min_reg <= SMALL_MIN_RESET;
            small_max_reg <= SMALL_MAX_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SMALL_MIN: small_min_reg <= cfg_data;
                CFG_SMALL_MAX: small_max_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    cia_front #(.W(W)) u_front (
        .operation (s_axis_tdata[3:0]),
        .operand_a (s_axis_tdata[67:4]),
        .operand_b (s_axis_tdata[131:68]),
        .a_is_int  (s_axis_tuser[0]),
        .b_is_int  (s_axis_tuser[1]),
        .ctl       (f_ctl),
        .val       (f_val),
        .mag_a     (f_mag_a),
        .mag_b     (f_mag_b)
    );

    cia_queue #(.WIDTH(QW), .DEPTH(2)) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (s_axis_tvalid),
        .wr_ready (s_axis_tready),
        .wr_data  ({f_ctl, f_val, f_mag_a, f_mag_b}),
        .rd_valid (q_rd_valid),
        .rd_ready (q_rd_ready),
        .rd_data  (q_rd_data)
    );

    assign {q_ctl, q_val, q_mag_a, q_mag_b} = q_rd_data;

    cia_back #(.W(W)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (q_rd_valid),
        .in_ready   (q_rd_ready),
        .in_ctl     (q_ctl),
        .in_val     (q_val),
        .in_mag_a   (q_mag_a),
        .in_mag_b   (q_mag_b),
        .small_min  (small_min_reg),
        .small_max  (small_max_reg),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_value  (r_value),
        .out_truth  (r_truth),
        .out_status (r_status),
        .out_box    (r_box)
    );

    assign m_axis_tdata = {4'b0, r_box, r_status, r_truth, r_value};

    a_fail_is_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (r_status != ST_OK) |-> (r_value == '0) && !r_box && !r_truth)
        else $error("failed operation carries a nonzero result");

    a_truth_no_value: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && r_truth |-> (r_value == '0) && !r_box)
        else $error("comparison result carries a value or box flag");

    a_box_needs_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && r_box && ($signed(small_min_reg) <= $signed(small_max_reg))
        |-> ($signed(r_value) < $signed(small_min_reg))
         || ($signed(r_value) > $signed(small_max_reg)))
        else $error("box flag set for a value inside the small range");
endmodule
`default_nettype wire

// File: rtl/cia_front.sv
// Front end: narrows operands, checks types and classifies each operation.
`default_nettype none
module cia_front
    import cia_pkg::*;
#(
    parameter int W = 64
) (
    input  wire logic [OP_W-1:0] operation,
    input  wire logic [63:0]     operand_a,
    input  wire logic [63:0]     operand_b,
    input  wire logic            a_is_int,
    input  wire logic            b_is_int,
    output ctl_t                 ctl,
    output logic [W-1:0]         val,
    output logic [W-1:0]         mag_a,
    output logic [W-1:0]         mag_b
);
    logic [W-1:0] a;
    logic [W-1:0] b;
    logic [W:0]   sum;
    logic [W:0]   diff;
    logic         lt;
    logic         a_is_min;

    assign a = operand_a[W-1:0];
    assign b = operand_b[W-1:0];
    assign sum  = {a[W-1], a} + {b[W-1], b};
    assign diff = {a[W-1], a} - {b[W-1], b};
    assign lt = $signed(a) < $signed(b);
    assign a_is_min = (a == {1'b1, {(W-1){1'b0}}});
    assign mag_a = a[W-1] ? (~a + 1'b1) : a;
    assign mag_b = b[W-1] ? (~b + 1'b1) : b;

    always_comb
    begin
        ctl.op     = operation;
        ctl.status = ST_OK;
        ctl.truth  = 1'b0;
        ctl.neg_q  = a[W-1] ^ b[W-1];
        ctl.neg_r  = a[W-1];
        val        = '0;
        if (operation <= OP_GE && !(a_is_int && b_is_int))
        begin
            ctl.status = ST_BADTYPE;
        end
        else
        begin
            unique case (operation) inside
                OP_ADD:
                begin
                    if (sum[W] != sum[W-1]) ctl.status = ST_OVERFLOW;
                    else                    val = sum[W-1:0];
                end
                OP_SUB:
                begin
                    if (diff[W] != diff[W-1]) ctl.status = ST_OVERFLOW;
                    else                      val = diff[W-1:0];
                end
                OP_DIV, OP_REM:
                begin
                    if (b == '0)
                        ctl.status = ST_DIVZERO;
                    else if (operation == OP_DIV && a_is_min && (&b))
                        ctl.status = ST_OVERFLOW;
                end
                OP_LT: ctl.truth = lt;
                OP_LE: ctl.truth = lt || (a == b);
                OP_GT: ctl.truth = !lt && (a != b);
                OP_GE: ctl.truth = !lt;
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: rtl/cia_queue.sv
// Small register FIFO that decouples the front end from the execution pipeline.
`default_nettype none
module cia_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_valid,
    output logic                  wr_ready,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  rd_valid,
    input  wire logic             rd_ready,
    output logic [WIDTH-1:0]      rd_data
);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PW-1:0]    wptr_reg;
    logic [PW-1:0]    rptr_reg;
    logic [CW-1:0]    count_reg;
    logic             push;
    logic             pop;

    assign wr_ready = (count_reg != FULL);
    assign rd_valid = (count_reg != '0);
    assign rd_data  = entry_reg[rptr_reg];
    assign push = wr_valid && wr_ready;
    assign pop  = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (push) entry_reg[wptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push) wptr_reg <= (wptr_reg == LAST) ? '0 : wptr_reg + 1'b1;
            if (pop)  rptr_reg <= (rptr_reg == LAST) ? '0 : rptr_reg + 1'b1;
            if (push && !pop)      count_reg <= count_reg + 1'b1;
            else if (pop && !push) count_reg <= count_reg - 1'b1;
        end
    end
endmodule
`default_nettype wire

// File: rtl/cia_back.sv
// Execution pipeline: staged multiplier, one-bit-per-stage divider and result register.
`default_nettype none
module cia_back
    import cia_pkg::*;
#(
    parameter int W = 64
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire ctl_t            in_ctl,
    input  wire logic [W-1:0]    in_val,
    input  wire logic [W-1:0]    in_mag_a,
    input  wire logic [W-1:0]    in_mag_b,
    input  wire logic [63:0]     small_min,
    input  wire logic [63:0]     small_max,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output logic [63:0]          out_value,
    output logic                 out_truth,
    output logic [ST_W-1:0]      out_status,
    output logic                 out_box
);
    localparam int H = (W + 1) / 2;
    localparam int PWID = 4 * H;
    localparam logic [PWID-1:0] LIM = PWID'(1) << (W - 1);

    // Divider stages; the item rides along with its divide state.
    ctl_t         ctl_reg [W];
    logic [W-1:0] val_reg [W];
    logic [W-1:0] rem_reg [W];
    logic [W-1:0] dvd_reg [W];
    logic [W-1:0] dvs_reg [W];
    logic [W-1:0] quo_reg [W];
    logic         vld_reg [W];
    ctl_t         ctl_next [W];
    logic [W-1:0] val_next [W];
    logic [W-1:0] rem_next [W];
    logic [W-1:0] dvd_next [W];
    logic [W-1:0] dvs_next [W];
    logic [W-1:0] quo_next [W];

    // Multiplier partial products (aligned with stage 0) and product (stage 1).
    logic [2*H-1:0]  pp_ll_reg, pp_lh_reg, pp_hl_reg, pp_hh_reg;
    logic [PWID-1:0] prod_reg;
    logic [H-1:0]    a_lo, a_hi, b_lo, b_hi;
    logic            mul_ovf;
    logic [W-1:0]    mul_val;

    logic            en;
    logic            out_valid_reg;
    logic [63:0]     value_reg;
    logic            truth_reg;
    logic [ST_W-1:0] status_reg;
    logic            box_reg;
    logic [W-1:0]    fin_val;
    logic [63:0]     fin_val64;
    logic            fin_arith;

    assign en = !out_valid_reg || out_ready;
    assign in_ready = en;

    assign a_lo = in_mag_a[H-1:0];
    assign a_hi = H'(in_mag_a >> H);
    assign b_lo = in_mag_b[H-1:0];
    assign b_hi = H'(in_mag_b >> H);

    assign mul_ovf = ctl_reg[1].neg_q ? (prod_reg > LIM) : (prod_reg >= LIM);
    assign mul_val = ctl_reg[1].neg_q ? (~prod_reg[W-1:0] + 1'b1) : prod_reg[W-1:0];

    always_comb
    begin
        for (int i = 0; i < W; i++)
        begin
            logic [W-1:0] r, d, s, q, v;
            logic [W:0]   t;
            logic         ge;
            ctl_t         c;
            if (i == 0)
            begin
                c = in_ctl; v = in_val; r = '0; d = in_mag_a; s = in_mag_b; q = '0;
            end
            else
            begin
                c = ctl_reg[i-1]; v = val_reg[i-1]; r = rem_reg[i-1];
                d = dvd_reg[i-1]; s = dvs_reg[i-1]; q = quo_reg[i-1];
            end
            t  = {r, d[W-1]};
            ge = (t >= {1'b0, s});
            rem_next[i] = ge ? W'(t - {1'b0, s}) : t[W-1:0];
            quo_next[i] = {q[W-2:0], ge};
            dvd_next[i] = d << 1;
            dvs_next[i] = s;
            // The product is ready alongside stage 1 and folds in on the way to stage 2.
            if (i == 2 && c.op == OP_MUL && c.status == ST_OK)
            begin
                if (mul_ovf) c.status = ST_OVERFLOW;
                else         v = mul_val;
            end
            ctl_next[i] = c;
            val_next[i] = v;
        end
    end

    always_comb
    begin
        fin_arith = (ctl_reg[W-1].op <= OP_REM) && (ctl_reg[W-1].status == ST_OK);
        case (ctl_reg[W-1].op) inside
            OP_ADD, OP_SUB, OP_MUL: fin_val = val_reg[W-1];
            OP_DIV: fin_val = ctl_reg[W-1].neg_q ? (~quo_reg[W-1] + 1'b1) : quo_reg[W-1];
            OP_REM: fin_val = ctl_reg[W-1].neg_r ? (~rem_reg[W-1] + 1'b1) : rem_reg[W-1];
            default: fin_val = '0;
        endcase
        if (!fin_arith) fin_val = '0;
        fin_val64 = 64'($signed(fin_val));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < W; i++)
            begin
                ctl_reg[i] <= ctl_next[i];
                val_reg[i] <= val_next[i];
                rem_reg[i] <= rem_next[i];
                dvd_reg[i] <= dvd_next[i];
                dvs_reg[i] <= dvs_next[i];
                quo_reg[i] <= quo_next[i];
            end
            pp_ll_reg <= a_lo * b_lo;
            pp_lh_reg <= a_lo * b_hi;
            pp_hl_reg <= a_hi * b_lo;
            pp_hh_reg <= a_hi * b_hi;
            prod_reg  <= (PWID'(pp_hh_reg) << (2 * H))
                       + ((PWID'(pp_lh_reg) + PWID'(pp_hl_reg)) << H)
                       + PWID'(pp_ll_reg);
            value_reg  <= fin_val64;
            truth_reg  <= ctl_reg[W-1].truth;
            status_reg <= ctl_reg[W-1].status;
            box_reg    <= fin_arith && (($signed(fin_val64) < $signed(small_min))
                                     || ($signed(fin_val64) > $signed(small_max)));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < W; i++) vld_reg[i] <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < W; i++) vld_reg[i] <= vld_reg[i-1];
            out_valid_reg <= vld_reg[W-1];
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_value  = value_reg;
    assign out_truth  = truth_reg;
    assign out_status = status_reg;
    assign out_box    = box_reg;
endmodule
`default_nettype wire

// File: tb/sv/testbench.sv
// Self-checking testbench of the checked integer ALU with a result scoreboard.
`default_nettype none
module testbench;
    import cia_pkg::*;

    localparam logic [63:0] MOST_NEG = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MOST_POS = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam int LATENCY = 80;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic            needs_box;
        logic [ST_W-1:0] status;
        logic            truth;
        logic [63:0]     value;
    } alu_result_t;

    class alu_scoreboard;
        logic [63:0] small_min;
        logic [63:0] small_max;
        alu_result_t pending[$];
        int errors;

        function new();
            small_min = SMALL_MIN_RESET;
            small_max = SMALL_MAX_RESET;
            errors = 0;
        endfunction

        function alu_result_t compute(logic [OP_W-1:0] op, logic signed [63:0] a,
                                      logic signed [63:0] b, logic a_int, logic b_int);
            alu_result_t r;
            logic signed [127:0] wide;
            logic arith;
            r = '0;
            arith = 1'b0;
            if (op <= OP_GE && !(a_int && b_int))
                r.status = ST_BADTYPE;
            else
                case (op) inside
                    OP_ADD, OP_SUB, OP_MUL:
                    begin
                        if (op == OP_ADD) wide = 128'(a) + 128'(b);
                        else if (op == OP_SUB) wide = 128'(a) - 128'(b);
                        else wide = 128'(a) * 128'(b);
                        if (wide > 128'(signed'(MOST_POS)) || wide < 128'(signed'(MOST_NEG)))
                            r.status = ST_OVERFLOW;
                        else
                        begin
                            r.value = wide[63:0];
                            arith = 1'b1;
                        end
                    end
                    OP_DIV, OP_REM:
                    begin
                        if (b == 0)
                            r.status = ST_DIVZERO;
                        else if (a == signed'(MOST_NEG) && b == -1)
                        begin
                            // The quotient does not fit; the remainder is simply zero.
                            if (op == OP_DIV) r.status = ST_OVERFLOW;
                            else arith = 1'b1;
                        end
                        else
                        begin
                            r.value = (op == OP_DIV) ? a / b : a % b;
                            arith = 1'b1;
                        end
                    end
                    OP_LT: r.truth = a < b;
                    OP_LE: r.truth = a <= b;
                    OP_GT: r.truth = a > b;
                    OP_GE: r.truth = a >= b;
                    default: ;
                endcase
            if (arith)
                r.needs_box = signed'(r.value) < signed'(small_min)
                              || signed'(r.value) > signed'(small_max);
            return r;
        endfunction

        function void note_operation(logic [135:0] data, logic [1:0] user);
            pending.push_back(compute(data[3:0], data[67:4], data[131:68], user[0], user[1]));
        endfunction

        function void check_result(logic [71:0] data);
            alu_result_t exp;
            alu_result_t got;
            got = data[67:0];
            if (pending.size() == 0)
            begin
                $error("unexpected result transaction %h", data);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.value !== exp.value)
            begin
                $error("result_value: expected %h, actual %h", exp.value, got.value);
                errors++;
            end
            if (got.truth !== exp.truth)
            begin
                $error("truth: expected %b, actual %b", exp.truth, got.truth);
                errors++;
            end
            if (got.status !== exp.status)
            begin
                $error("status: expected %0d, actual %0d", exp.status, got.status);
                errors++;
            end
            if (got.needs_box !== exp.needs_box)
            begin
                $error("needs_box: expected %b, actual %b", exp.needs_box, got.needs_box);
                errors++;
            end
            if (data[71:68] !== 4'b0)
            begin
                $error("pad bits: expected 0, actual %h", data[71:68]);
                errors++;
            end
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [135:0] s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [71:0]  m_axis_tdata;
    logic         cfg_we;
    logic         cfg_index;
    logic [63:0]  cfg_data;

    alu_scoreboard board;
    int  send_idle_pct;
    int  stall_pct;
    int  hold_off;
    longint cycles;

    checked_integer_alu i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Receiver: random stalls, plus a long hold-off when one is requested.
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_off--;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tdata);
        if (rst_n && s_axis_tvalid && s_axis_tready)
            board.note_operation(s_axis_tdata, s_axis_tuser);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("checked_integer_alu test failed");
            $finish;
        end
    end

    function automatic logic [63:0] pick_operand();
        case ($urandom_range(9))
            0: return MOST_NEG;
            1: return MOST_POS;
            2: return 64'd0;
            3: return '1;
            4: return 64'd1;
            5: return {$urandom, $urandom} >>> $urandom_range(63);
            6: return 64'(signed'($urandom_range(200)) - 100);
            7: return {{32{$urandom_range(1) == 1}}, $urandom};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_operation(logic [OP_W-1:0] op, logic [63:0] a, logic [63:0] b,
                                  logic a_int, logic b_int);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, b, a, op};
        s_axis_tuser  <= {b_int, a_int};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_random(int count);
        logic [OP_W-1:0] op;
        logic a_int;
        logic b_int;
        repeat (count)
        begin
            op = ($urandom_range(19) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(8));
            a_int = $urandom_range(9) != 0;
            b_int = $urandom_range(9) != 0;
            send_operation(op, pick_operand(), pick_operand(), a_int, b_int);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (board.pending.size() != 0)
            @(negedge clk);
        repeat (LATENCY) @(negedge clk);
    endtask

    task automatic write_register(logic index, logic [63:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (index == CFG_SMALL_MIN) board.small_min = value;
        else board.small_max = value;
        @(negedge clk);
    endtask

    initial
    begin
        board = new();
        cycles = 0;
        hold_off = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_SMALL_MIN;
        cfg_data = '0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed corners under the reset range.
        send_operation(OP_ADD, MOST_POS, 64'd1, 1'b1, 1'b1);
        send_operation(OP_ADD, MOST_NEG, '1, 1'b1, 1'b1);
        send_operation(OP_ADD, 64'h0800_0000_0000_0000, 64'd0, 1'b1, 1'b1);
        send_operation(OP_SUB, MOST_NEG, 64'd1, 1'b1, 1'b1);
        send_operation(OP_SUB, MOST_POS, '1, 1'b1, 1'b1);
        send_operation(OP_SUB, 64'd5, 64'd9, 1'b1, 1'b1);
        send_operation(OP_MUL, MOST_NEG, '1, 1'b1, 1'b1);
        send_operation(OP_MUL, 64'h1_0000_0000, 64'h8000_0000, 1'b1, 1'b1);
        send_operation(OP_MUL, '1, MOST_POS, 1'b1, 1'b1);
        send_operation(OP_DIV, MOST_NEG, '1, 1'b1, 1'b1);
        send_operation(OP_REM, MOST_NEG, '1, 1'b1, 1'b1);
        send_operation(OP_DIV, 64'd7, 64'd0, 1'b1, 1'b1);
        send_operation(OP_REM, 64'd7, 64'd0, 1'b1, 1'b1);
        send_operation(OP_DIV, -64'sd7, 64'd2, 1'b1, 1'b1);
        send_operation(OP_REM, -64'sd7, 64'd2, 1'b1, 1'b1);
        send_operation(OP_REM, 64'd7, -64'sd2, 1'b1, 1'b1);
        send_operation(OP_LT, MOST_NEG, MOST_POS, 1'b1, 1'b1);
        send_operation(OP_LE, 64'd3, 64'd3, 1'b1, 1'b1);
        send_operation(OP_GT, MOST_NEG, MOST_POS, 1'b1, 1'b1);
        send_operation(OP_GE, 64'd3, 64'd3, 1'b1, 1'b1);
        send_operation(OP_ADD, 64'd1, 64'd1, 1'b0, 1'b1);
        send_operation(OP_LT, 64'd1, 64'd2, 1'b1, 1'b0);
        send_operation(4'd9, 64'd1, 64'd2, 1'b0, 1'b0);
        send_operation(4'd15, MOST_POS, MOST_NEG, 1'b1, 1'b1);
        drain();

        // Fill the block against a stalled receiver, then pause until it empties.
        hold_off = 300;
        send_random(120);
        drain();

        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 63;
                    stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct = 63;
                end
                default:
                begin
                    send_idle_pct = 16;
                    stall_pct = 16;
                end
            endcase
            case (phase)
                1:
                begin
                    write_register(CFG_SMALL_MIN, MOST_NEG);
                    write_register(CFG_SMALL_MAX, MOST_POS);
                end
                2:
                begin
                    write_register(CFG_SMALL_MIN, 64'd0);
                    write_register(CFG_SMALL_MAX, 64'd0);
                end
                3:
                begin
                    write_register(CFG_SMALL_MIN, 64'd100);
                    write_register(CFG_SMALL_MAX, -64'sd100);
                end
                4:
                begin
                    write_register(CFG_SMALL_MIN, MOST_POS);
                    write_register(CFG_SMALL_MAX, MOST_NEG);
                end
                5:
                begin
                    write_register(CFG_SMALL_MIN, -64'sd50);
                    write_register(CFG_SMALL_MAX, 64'd50);
                end
                6:
                begin
                    write_register(CFG_SMALL_MIN, {$urandom, $urandom});
                    write_register(CFG_SMALL_MAX, {$urandom, $urandom});
                end
                7:
                begin
                    write_register(CFG_SMALL_MIN, SMALL_MIN_RESET);
                    write_register(CFG_SMALL_MAX, SMALL_MAX_RESET);
                end
                default: ;
            endcase
            send_random(175);
            drain();
        end

        if (board.errors == 0)
            $display("checked_integer_alu test passed");
        else
            $display("checked_integer_alu test failed");
        $finish;
    end
endmodule
`default_nettype wire

// File: filelist.f
rtl/cia_pkg.sv
rtl/cia_front.sv
rtl/cia_queue.sv
rtl/cia_back.sv
rtl/checked_integer_alu.sv
tb/sv/testbench.sv
